[hdl/ftl_pkg.sv]
// Shared types, sizes and codes for the page-mapped flash translation layer.
// Used by the page-state store, the top level and the port checker.
package ftl_pkg;

	localparam int BLOCKS          = 16;
	localparam int PAGES_PER_BLOCK = 16;
	localparam int LOGICAL_BLOCKS  = 8;
	localparam int PHYS_PAGES      = BLOCKS * PAGES_PER_BLOCK;
	localparam int LOG_PAGES       = LOGICAL_BLOCKS * PAGES_PER_BLOCK;
	localparam int NO_VALID_COUNT  = 512;
	localparam int NP_GUARD        = 2 * PHYS_PAGES + 4;

	localparam int BLK_W   = $clog2(BLOCKS);
	localparam int PG_W    = $clog2(PAGES_PER_BLOCK);
	localparam int PA_W    = $clog2(PHYS_PAGES);
	localparam int LA_W    = (LOG_PAGES > 1) ? $clog2(LOG_PAGES) : 1;
	localparam int CNT_W   = $clog2(PAGES_PER_BLOCK + 1);
	localparam int MINC_W  = $clog2(NO_VALID_COUNT + 1);
	localparam int GUARD_W = $clog2(NP_GUARD + 1);

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNMAPPED  = 2'd1;
	localparam logic [1:0] ST_GC_FAIL   = 2'd2;

	typedef enum logic [1:0] {
		PG_EMPTY = 2'd0,
		PG_VALID = 2'd1,
		PG_STALE = 2'd2
	} pg_state_t;

	typedef struct packed {
		logic             mapped;
		logic [BLK_W-1:0] blk;
		logic [PG_W-1:0]  pg;
	} map_ent_t;

	typedef struct packed {
		logic [PA_W-1:0]  addr;
		logic             we;
		pg_state_t        wdata;
		logic             erase;
		logic [BLK_W-1:0] erase_blk;
	} ps_req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MAP_RD, S_MAP_CHK, S_RD_PS, S_RD_CHK, S_WR_PS, S_WR_CHK, S_COMMIT,
		S_NP_RD, S_NP_CHK, S_GC_INIT, S_GC_SC_RD, S_GC_SC_CHK, S_GC_ST_RD, S_GC_ST_CHK,
		S_GC_MV, S_MV_LOOP, S_MV_FP_RD, S_MV_FP_CHK, S_MV_TP_RD, S_MV_TP_CHK,
		S_MV_MAP_RD, S_MV_MAP_CHK, S_MV_SWAP1, S_MV_SWAP2, S_MV_ERASE, S_GC_RET,
		S_FAIL, S_DONE
	} ftl_state_t;

	function automatic logic [PA_W-1:0] ps_addr(input logic [BLK_W-1:0] blk,
			input logic [PG_W-1:0] pg);
		ps_addr = PA_W'(int'(blk) * PAGES_PER_BLOCK + int'(pg));
	endfunction

endpackage

[hdl/ftl_ps_store.sv]
// Page-state store: one two-bit state per physical page, registered read.
// Per-page valid flops make never-written and erased pages read as empty.
// Depends on ftl_pkg.
module ftl_ps_store (
	input  logic             clk,
	input  logic             arst_n,
	input  ftl_pkg::ps_req_t req,
	output ftl_pkg::pg_state_t rdata
);
	import ftl_pkg::*;

	pg_state_t mem [PHYS_PAGES];
	logic [PHYS_PAGES-1:0] vld_q;
	pg_state_t rd_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rd_q <= mem[req.addr];
	end

	// An erase clears the whole block at once through its valid flops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[req.addr];
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end else if (req.erase) begin
				for (int b = 0; b < BLOCKS; b++) begin
					for (int p = 0; p < PAGES_PER_BLOCK; p++) begin
						if (req.erase_blk == BLK_W'(b)) begin
							vld_q[b * PAGES_PER_BLOCK + p] <= 1'b0;
						end
					end
				end
			end
		end
	end

	assign rdata = rvld_q ? rd_q : PG_EMPTY;

endmodule

[hdl/page_mapped_ftl_with_gc.sv]
// Page-mapped flash translation layer with greedy garbage collection.
// One item is taken at a time: in_ready is high only while the block is idle, and the
// result is held on the output until taken. Every table access goes through a registered
// read, so the sequencer spends a request state and a check state on each lookup.
// Collection scans every physical page twice, and each moved page adds a full pass over
// the map. No clearing pass is needed after reset; valid flops cover both tables.
module page_mapped_ftl_with_gc (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [6:0] lba,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] phys_block,
	output logic [3:0] phys_page
);
	import ftl_pkg::*;

	ftl_state_t state_q, state_d;
	ps_req_t    ps_req;
	pg_state_t  ps_st;

	logic             kind_q;
	logic [6:0]       lba_q;
	logic [BLK_W-1:0] cur_blk_q, wb_q, b_q, min_blk_q, max_blk_q;
	logic [PG_W-1:0]  cur_pg_q, wp_q, p_q;
	logic [GUARD_W-1:0] guard_q;
	logic             np_ret_q, gc_final_q, done_q;
	logic [CNT_W-1:0] vcnt_q, ecnt_q, scnt_q, max_cnt_q, n_q, fp_q, tp_q;
	logic [MINC_W-1:0] min_cnt_q;
	logic [LA_W-1:0]  mi_q;
	logic [1:0]       status_q;
	logic [3:0]       phys_block_q, phys_page_q;

	map_ent_t map_mem [LOG_PAGES];
	logic [LOG_PAGES-1:0] map_vld_q;
	map_ent_t map_rd_q, map_wdata, ent;
	logic map_rvld_q, map_we;
	logic [LA_W-1:0] map_addr;

	logic lba_ok, last_blk, last_pg, blk_end, blk_last, move_ok;
	logic [CNT_W-1:0] vn, en, sn;
	ftl_state_t np_back;

	ftl_ps_store u_ps (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ps_req),
		.rdata (ps_st)
	);

	assign lba_ok   = 32'(lba_q) < LOG_PAGES;
	assign last_blk = wb_q == BLK_W'(BLOCKS - 1);
	assign last_pg  = wp_q == PG_W'(PAGES_PER_BLOCK - 1);
	assign blk_end  = p_q == PG_W'(PAGES_PER_BLOCK - 1);
	assign blk_last = b_q == BLK_W'(BLOCKS - 1);
	assign vn = vcnt_q + CNT_W'(ps_st == PG_VALID);
	assign en = ecnt_q + CNT_W'(ps_st == PG_EMPTY);
	assign sn = scnt_q + CNT_W'(ps_st == PG_STALE);
	assign move_ok = (min_blk_q != max_blk_q) && (min_cnt_q <= MINC_W'(max_cnt_q));
	assign np_back = np_ret_q ? S_COMMIT : S_WR_PS;
	assign ent = map_rvld_q ? map_rd_q : '0;

	// Map table with valid flops; unwritten entries read as unmapped.
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_addr] <= map_wdata;
		end
		map_rd_q <= map_mem[map_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q  <= '0;
			map_rvld_q <= 1'b0;
		end else begin
			map_rvld_q <= map_vld_q[map_addr];
			if (map_we) begin
				map_vld_q[map_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_MAP_RD;
			S_MAP_RD:    state_d = S_MAP_CHK;
			S_MAP_CHK: begin
				if (!lba_ok) state_d = S_DONE;
				else if (!kind_q) state_d = ent.mapped ? S_RD_PS : S_DONE;
				else state_d = ent.mapped ? S_WR_PS : S_NP_RD;
			end
			S_RD_PS:     state_d = S_RD_CHK;
			S_RD_CHK:    state_d = S_DONE;
			S_WR_PS:     state_d = S_WR_CHK;
			S_WR_CHK:    state_d = (ps_st == PG_VALID) ? S_NP_RD : S_COMMIT;
			S_COMMIT:    state_d = S_DONE;
			S_NP_RD:     state_d = (guard_q >= GUARD_W'(NP_GUARD)) ? S_FAIL : S_NP_CHK;
			S_NP_CHK: begin
				if (ps_st == PG_EMPTY) state_d = np_back;
				else if (last_pg) state_d = S_GC_INIT;
				else state_d = S_NP_RD;
			end
			S_GC_INIT:   state_d = S_GC_SC_RD;
			S_GC_SC_RD:  state_d = S_GC_SC_CHK;
			S_GC_SC_CHK: state_d = (blk_end && blk_last) ? S_GC_ST_RD : S_GC_SC_RD;
			S_GC_ST_RD:  state_d = S_GC_ST_CHK;
			S_GC_ST_CHK: state_d = (blk_end && blk_last) ? S_GC_MV : S_GC_ST_RD;
			S_GC_MV:     state_d = move_ok ? S_MV_LOOP : S_GC_RET;
			S_MV_LOOP:   state_d = (MINC_W'(n_q) >= min_cnt_q) ? S_MV_ERASE : S_MV_FP_RD;
			S_MV_FP_RD:  state_d = (fp_q >= CNT_W'(PAGES_PER_BLOCK)) ? S_MV_ERASE : S_MV_FP_CHK;
			S_MV_FP_CHK: state_d = (ps_st == PG_VALID) ? S_MV_TP_RD : S_MV_FP_RD;
			S_MV_TP_RD:  state_d = (tp_q >= CNT_W'(PAGES_PER_BLOCK)) ? S_MV_ERASE : S_MV_TP_CHK;
			S_MV_TP_CHK: state_d = (ps_st == PG_EMPTY) ? S_MV_MAP_RD : S_MV_TP_RD;
			S_MV_MAP_RD: state_d = S_MV_MAP_CHK;
			S_MV_MAP_CHK:
				state_d = (mi_q == LA_W'(LOG_PAGES - 1)) ? S_MV_SWAP1 : S_MV_MAP_RD;
			S_MV_SWAP1:  state_d = S_MV_SWAP2;
			S_MV_SWAP2:  state_d = S_MV_LOOP;
			S_MV_ERASE:  state_d = S_GC_RET;
			S_GC_RET: begin
				if (!gc_final_q) state_d = S_NP_RD;
				else state_d = done_q ? np_back : S_FAIL;
			end
			S_FAIL:      state_d = S_DONE;
			S_DONE:      if (out_ready) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Table port control per state.
	always_comb begin
		ps_req = '{addr: ps_addr(cur_blk_q, cur_pg_q), we: 1'b0, wdata: PG_EMPTY,
			erase: 1'b0, erase_blk: min_blk_q};
		map_addr  = lba_ok ? LA_W'(lba_q) : '0;
		map_we    = 1'b0;
		map_wdata = '{mapped: 1'b1, blk: cur_blk_q, pg: cur_pg_q};
		case (state_q)
			S_WR_CHK: begin
				ps_req.we    = ps_st == PG_VALID;
				ps_req.wdata = PG_STALE;
			end
			S_COMMIT: begin
				ps_req.we    = 1'b1;
				ps_req.wdata = PG_VALID;
				map_we       = 1'b1;
			end
			S_NP_RD: ps_req.addr = ps_addr(wb_q, wp_q);
			S_GC_SC_RD, S_GC_ST_RD: ps_req.addr = ps_addr(b_q, p_q);
			S_GC_ST_CHK: begin
				ps_req.erase     = blk_end && (sn == CNT_W'(PAGES_PER_BLOCK));
				ps_req.erase_blk = b_q;
			end
			S_MV_FP_RD: ps_req.addr = ps_addr(min_blk_q, fp_q[PG_W-1:0]);
			S_MV_TP_RD: ps_req.addr = ps_addr(max_blk_q, tp_q[PG_W-1:0]);
			S_MV_MAP_RD: map_addr = mi_q;
			S_MV_MAP_CHK: begin
				map_addr  = mi_q;
				map_wdata = '{mapped: 1'b1, blk: max_blk_q, pg: tp_q[PG_W-1:0]};
				map_we    = ent.mapped && (ent.blk == min_blk_q) &&
					(ent.pg == fp_q[PG_W-1:0]);
			end
			S_MV_SWAP1: begin
				ps_req.addr  = ps_addr(min_blk_q, fp_q[PG_W-1:0]);
				ps_req.we    = 1'b1;
				ps_req.wdata = PG_STALE;
			end
			S_MV_SWAP2: begin
				ps_req.addr  = ps_addr(max_blk_q, tp_q[PG_W-1:0]);
				ps_req.we    = 1'b1;
				ps_req.wdata = PG_VALID;
			end
			S_MV_ERASE: ps_req.erase = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wb_q    <= '0;
			wp_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_NP_CHK: begin
					if (ps_st != PG_EMPTY && !(last_blk && last_pg)) begin
						if (last_pg) begin
							wb_q <= wb_q + 1'b1;
							wp_q <= '0;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
					end
				end
				S_GC_ST_CHK: begin
					if (blk_end && (sn == CNT_W'(PAGES_PER_BLOCK))) begin
						wb_q <= b_q;
						wp_q <= '0;
					end
				end
				S_MV_ERASE: begin
					wb_q <= min_blk_q;
					wp_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= kind;
				lba_q  <= lba;
			end
			S_MAP_CHK: begin
				cur_blk_q <= ent.blk;
				cur_pg_q  <= ent.pg;
				np_ret_q  <= 1'b0;
				guard_q   <= '0;
				status_q     <= ST_UNMAPPED;
				phys_block_q <= '0;
				phys_page_q  <= '0;
			end
			S_RD_CHK: begin
				if (ps_st == PG_VALID) begin
					status_q     <= ST_OK;
					phys_block_q <= 4'(cur_blk_q);
					phys_page_q  <= 4'(cur_pg_q);
				end
			end
			S_WR_CHK: begin
				np_ret_q <= 1'b1;
				guard_q  <= '0;
			end
			S_COMMIT: begin
				status_q     <= ST_OK;
				phys_block_q <= 4'(cur_blk_q);
				phys_page_q  <= 4'(cur_pg_q);
			end
			S_NP_CHK: begin
				if (ps_st == PG_EMPTY) begin
					cur_blk_q <= wb_q;
					cur_pg_q  <= wp_q;
				end else begin
					gc_final_q <= last_blk && last_pg;
					if (!(last_blk && last_pg)) guard_q <= guard_q + 1'b1;
				end
			end
			S_GC_INIT: begin
				b_q <= '0;
				p_q <= '0;
				vcnt_q <= '0;
				ecnt_q <= '0;
				scnt_q <= '0;
				min_blk_q <= '0;
				min_cnt_q <= MINC_W'(NO_VALID_COUNT);
				max_blk_q <= '0;
				max_cnt_q <= '0;
				done_q <= 1'b0;
			end
			S_GC_SC_CHK: begin
				if (blk_end) begin
					if (vn != '0 && min_cnt_q > MINC_W'(vn)) begin
						min_blk_q <= b_q;
						min_cnt_q <= MINC_W'(vn);
					end
					if (en > max_cnt_q) begin
						max_blk_q <= b_q;
						max_cnt_q <= en;
					end
					vcnt_q <= '0;
					ecnt_q <= '0;
					p_q <= '0;
					b_q <= blk_last ? '0 : b_q + 1'b1;
				end else begin
					vcnt_q <= vn;
					ecnt_q <= en;
					p_q <= p_q + 1'b1;
				end
			end
			S_GC_ST_CHK: begin
				if (blk_end) begin
					if (sn == CNT_W'(PAGES_PER_BLOCK)) done_q <= 1'b1;
					scnt_q <= '0;
					p_q <= '0;
					b_q <= b_q + 1'b1;
				end else begin
					scnt_q <= sn;
					p_q <= p_q + 1'b1;
				end
			end
			S_GC_MV: begin
				if (move_ok) done_q <= 1'b1;
				n_q  <= '0;
				fp_q <= '0;
				tp_q <= '0;
			end
			S_MV_FP_CHK: if (ps_st != PG_VALID) fp_q <= fp_q + 1'b1;
			S_MV_TP_CHK: begin
				if (ps_st != PG_EMPTY) tp_q <= tp_q + 1'b1;
				mi_q <= '0;
			end
			S_MV_MAP_CHK: mi_q <= mi_q + 1'b1;
			S_MV_SWAP2:   n_q <= n_q + 1'b1;
			S_GC_RET: begin
				cur_blk_q <= wb_q;
				cur_pg_q  <= wp_q;
			end
			S_FAIL: begin
				status_q     <= ST_GC_FAIL;
				phys_block_q <= '0;
				phys_page_q  <= '0;
			end
			default: ;
		endcase
	end

	assign in_ready   = state_q == S_IDLE;
	assign out_valid  = state_q == S_DONE;
	assign status     = status_q;
	assign phys_block = phys_block_q;
	assign phys_page  = phys_page_q;

endmodule

[hdl/ftl_checker.sv]
// Port-level checks for the translation layer, bound to the top level.
// Depends on ftl_pkg for the status codes.
module ftl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [3:0] phys_block,
	input logic [3:0] phys_page
);
	import ftl_pkg::*;

	// One item at a time: never ready for input while a result waits.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready again right after an item was accepted");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_UNMAPPED || status == ST_GC_FAIL))
		else $error("undefined status code");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (phys_block == 4'd0 && phys_page == 4'd0))
		else $error("page address not zero on an error result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("result dropped or changed while stalled");

endmodule

bind page_mapped_ftl_with_gc ftl_checker u_ftl_checker (.*);
